@@ sv/acfsm_pkg.sv @@
// ----------------------------------------------------------------------------
// acfsm_pkg
// Shared codes for the alarm confirm/hold state machine: state codes, alarm
// kind codes and configuration register indexes.
// ----------------------------------------------------------------------------
package acfsm_pkg;

  localparam int STATE_W = 3;
  localparam int KIND_W  = 4;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // alarm state codes as seen on out_alarm_state
  localparam logic [STATE_W-1:0] ST_NORMAL = 3'd0;
  localparam logic [STATE_W-1:0] ST_PRE    = 3'd1;
  localparam logic [STATE_W-1:0] ST_ACTIVE = 3'd2;
  localparam logic [STATE_W-1:0] ST_HOLD   = 3'd3;
  localparam logic [STATE_W-1:0] ST_FAULT  = 3'd4;

  // alarm kind codes
  localparam logic [KIND_W-1:0] KIND_NONE  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_FAULT = 4'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] CONFIRM_RST = 16'd500;
  localparam logic [CFG_W-1:0] HOLD_RST    = 16'd2000;

endpackage

@@ sv/alarm_confirm_hold_fsm.sv @@
// ----------------------------------------------------------------------------
// alarm_confirm_hold_fsm
// Confirm-then-hold alarm state machine with sensor fault override.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction is one update with
//   a sensor fault flag, an anomaly flag, an anomaly kind and a millisecond
//   timestamp. Result channel (out_valid / out_stall): one transaction per
//   update with the new alarm state, alarm kind and a state-changed flag.
//   Path: an accepted update passes through one input register and one result
//   register, with next-state logic holding a single 32-bit subtract and two
//   compares between them.
//   Throughput: one update per cycle while out_stall does not hold a result;
//   the state registers are updated in the same cycle that the result is
//   registered, so the next update sees them right away.
//   Stall: when out_stall holds a result, the input register stays full and
//   in_stall rises; nothing is dropped or duplicated.
//   Reset (rst_n low, synchronous): state normal, kind none, entry time 0,
//   confirm time 500 ms, hold time 2000 ms, both channels empty.
//   Configuration: cfg_we writes cfg_wdata to the register at cfg_index
//   (0 confirm time, 1 hold time); write only while the block is idle.
// ----------------------------------------------------------------------------
module alarm_confirm_hold_fsm (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [acfsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [acfsm_pkg::CFG_W-1:0]         cfg_wdata,
  // update channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_sensor_fault,
  input  logic                                in_anomaly_active,
  input  logic [acfsm_pkg::KIND_W-1:0]        in_anomaly_kind,
  input  logic [acfsm_pkg::TIME_W-1:0]        in_now_ms,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [acfsm_pkg::STATE_W-1:0]       out_alarm_state,
  output logic [acfsm_pkg::KIND_W-1:0]        out_alarm_kind,
  output logic                                out_state_changed
);

  typedef enum logic [acfsm_pkg::STATE_W-1:0] {
    S_NORMAL = acfsm_pkg::ST_NORMAL,
    S_PRE    = acfsm_pkg::ST_PRE,
    S_ACTIVE = acfsm_pkg::ST_ACTIVE,
    S_HOLD   = acfsm_pkg::ST_HOLD,
    S_FAULT  = acfsm_pkg::ST_FAULT
  } state_t;

  // configuration registers
  logic [acfsm_pkg::CFG_W-1:0]  confirm_r;
  logic [acfsm_pkg::CFG_W-1:0]  hold_r;

  // input register
  logic                         in_vld_r;
  logic                         fault_r;
  logic                         anom_r;
  logic [acfsm_pkg::KIND_W-1:0] akind_r;
  logic [acfsm_pkg::TIME_W-1:0] now_r;

  // machine state
  state_t                       state_r, state_nxt;
  logic [acfsm_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [acfsm_pkg::TIME_W-1:0] entered_r;

  // result register
  logic                           out_vld_r;
  logic [acfsm_pkg::STATE_W-1:0]  o_state_r;
  logic [acfsm_pkg::KIND_W-1:0]   o_kind_r;
  logic                           o_chg_r;

  logic                         advance;
  logic                         in_load;
  logic [acfsm_pkg::TIME_W-1:0] elapsed;
  logic                         confirm_done;
  logic                         hold_done;

  // pipeline control: the update in the input register moves to the result
  // register whenever that register is empty or being drained
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_load  = in_valid && !in_stall;

  // elapsed time wraps modulo 2^32
  assign elapsed      = now_r - entered_r;
  assign confirm_done = elapsed >= {{(acfsm_pkg::TIME_W-acfsm_pkg::CFG_W){1'b0}}, confirm_r};
  assign hold_done    = elapsed >= {{(acfsm_pkg::TIME_W-acfsm_pkg::CFG_W){1'b0}}, hold_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_r <= acfsm_pkg::CONFIRM_RST;
      hold_r    <= acfsm_pkg::HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acfsm_pkg::REG_CONFIRM: confirm_r <= cfg_wdata;
        acfsm_pkg::REG_HOLD:    hold_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      fault_r <= in_sensor_fault;
      anom_r  <= in_anomaly_active;
      akind_r <= in_anomaly_kind;
      now_r   <= in_now_ms;
    end
  end

  // next-state logic; fault overrides, kind follows the anomaly code outside the active state
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    if (fault_r) begin
      state_nxt = S_FAULT;
      kind_nxt  = acfsm_pkg::KIND_FAULT;
    end else begin
      unique case (state_r)
        S_PRE: begin
          if (anom_r) begin
            kind_nxt = akind_r;
            if (confirm_done) state_nxt = S_ACTIVE;
          end else begin
            kind_nxt  = acfsm_pkg::KIND_NONE;
            state_nxt = S_NORMAL;
          end
        end
        S_ACTIVE: begin
          // kind is frozen while the alert is active
          if (!anom_r) state_nxt = S_HOLD;
        end
        S_HOLD: begin
          if (anom_r) begin
            kind_nxt  = akind_r;
            state_nxt = S_ACTIVE;
          end else if (hold_done) begin
            kind_nxt  = acfsm_pkg::KIND_NONE;
            state_nxt = S_NORMAL;
          end
        end
        S_FAULT: begin
          // recovery ignores this update's anomaly inputs
          kind_nxt  = acfsm_pkg::KIND_NONE;
          state_nxt = S_NORMAL;
        end
        default: begin
          if (anom_r) begin
            kind_nxt  = akind_r;
            state_nxt = S_PRE;
          end
        end
      endcase
    end
  end

  // state, entry time and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_NORMAL;
      kind_r    <= acfsm_pkg::KIND_NONE;
      entered_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r   <= state_nxt;
        kind_r    <= kind_nxt;
        // restamp only on an actual state change
        if (state_nxt != state_r) entered_r <= now_r;
        out_vld_r <= 1'b1;
        o_state_r <= state_nxt;
        o_kind_r  <= kind_nxt;
        o_chg_r   <= (state_nxt != state_r);
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_vld_r;
  assign out_alarm_state   = o_state_r;
  assign out_alarm_kind    = o_kind_r;
  assign out_state_changed = o_chg_r;

endmodule

@@ sv/acfsm_checker.sv @@
// ----------------------------------------------------------------------------
// acfsm_checker
// Port-level checks for the alarm confirm/hold state machine.
// ----------------------------------------------------------------------------
module acfsm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [acfsm_pkg::STATE_W-1:0]  out_alarm_state,
  input logic [acfsm_pkg::KIND_W-1:0]   out_alarm_kind,
  input logic                           out_state_changed
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alarm_state)
      && $stable(out_alarm_kind) && $stable(out_state_changed))
    else $error("result changed while stalled");

  // fault state always reports the fault kind
  a_fault_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_state == acfsm_pkg::ST_FAULT
      |-> out_alarm_kind == acfsm_pkg::KIND_FAULT)
    else $error("fault state without fault kind");

  // normal state always reports no alarm
  a_normal_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_state == acfsm_pkg::ST_NORMAL
      |-> out_alarm_kind == acfsm_pkg::KIND_NONE)
    else $error("normal state with alarm kind");

  // only defined state codes are reported
  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alarm_state <= acfsm_pkg::ST_FAULT)
    else $error("undefined state code");

endmodule

bind alarm_confirm_hold_fsm acfsm_checker u_acfsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_alarm_state   (out_alarm_state),
  .out_alarm_kind    (out_alarm_kind),
  .out_state_changed (out_state_changed)
);

@@ bench/alarm_check_pkg.sv @@
// ----------------------------------------------------------------------------
// alarm_check_pkg
// Scoreboard for the alarm confirm/hold state machine: tracks the expected
// alarm state per update and compares it with what the block returns.
// ----------------------------------------------------------------------------
package alarm_check_pkg;
  import acfsm_pkg::*;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [KIND_W-1:0]  kind;
    logic               changed;
  } alarm_word_t;

  class alarm_scoreboard;
    logic [STATE_W-1:0] cur_state;
    logic [KIND_W-1:0]  cur_kind;
    logic [TIME_W-1:0]  entered_ms;
    logic [CFG_W-1:0]   confirm_ms;
    logic [CFG_W-1:0]   hold_ms;
    alarm_word_t        expected_q[$];
    int                 mismatches;
    int                 checked;
    int                 transitions;
    int                 state_hits[8];

    function new();
      cur_state   = ST_NORMAL;
      cur_kind    = KIND_NONE;
      entered_ms  = '0;
      confirm_ms  = CONFIRM_RST;
      hold_ms     = HOLD_RST;
      mismatches  = 0;
      checked     = 0;
      transitions = 0;
      foreach (state_hits[i]) state_hits[i] = 0;
    endfunction

    function void set_times(logic [CFG_W-1:0] confirm, logic [CFG_W-1:0] hold);
      confirm_ms = confirm;
      hold_ms    = hold;
    endfunction

    // Advance the alarm state for one accepted update and queue its result.
    function void note_update(logic fault, logic anomaly, logic [KIND_W-1:0] code,
                              logic [TIME_W-1:0] now);
      logic [STATE_W-1:0] prior;
      logic [STATE_W-1:0] nxt;
      logic [TIME_W-1:0]  elapsed;
      alarm_word_t        word;
      prior   = cur_state;
      nxt     = cur_state;
      elapsed = now - entered_ms;   // modulo 2^32
      if (fault) begin
        cur_kind = KIND_FAULT;
        nxt      = ST_FAULT;
      end else begin
        case (cur_state)
          ST_PRE: begin
            if (anomaly) begin
              cur_kind = code;
              if (elapsed >= TIME_W'(confirm_ms)) nxt = ST_ACTIVE;
            end else begin
              cur_kind = KIND_NONE;
              nxt      = ST_NORMAL;
            end
          end
          ST_ACTIVE: begin
            if (!anomaly) nxt = ST_HOLD;   // kind sticks while active
          end
          ST_HOLD: begin
            if (anomaly) begin
              cur_kind = code;
              nxt      = ST_ACTIVE;
            end else if (elapsed >= TIME_W'(hold_ms)) begin
              cur_kind = KIND_NONE;
              nxt      = ST_NORMAL;
            end
          end
          ST_FAULT: begin
            // recovery ignores the anomaly inputs
            cur_kind = KIND_NONE;
            nxt      = ST_NORMAL;
          end
          default: begin
            if (anomaly) begin
              cur_kind = code;
              nxt      = ST_PRE;
            end
          end
        endcase
      end
      if (nxt != cur_state) begin
        cur_state  = nxt;
        entered_ms = now;
        transitions++;
      end
      state_hits[cur_state]++;
      word.state   = cur_state;
      word.kind    = cur_kind;
      word.changed = (cur_state != prior);
      expected_q.push_back(word);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", what);
    endfunction

    function void check_result(logic [STATE_W-1:0] st, logic [KIND_W-1:0] kd, logic chg);
      alarm_word_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with nothing pending: state=%0d kind=%0d changed=%0d",
                       st, kd, chg));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.state !== st || want.kind !== kd || want.changed !== chg)
        flag($sformatf("result %0d: expected state=%0d kind=%0d changed=%0d, got %0d/%0d/%0d",
                       checked, want.state, want.kind, want.changed, st, kd, chg));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int failures();
      return mismatches + expected_q.size();
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for alarm_confirm_hold_fsm: directed walk through the
// fault, confirm, hold and wrap cases, then randomized anomaly runs under
// several confirm/hold settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acfsm_pkg::*;
  import alarm_check_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int SQUEEZE_CYCLES  = 60;    // long receiver hold-off
  localparam int SETTLE_CYCLES   = 4;     // margin after the last result; a little extra
  localparam int DRAIN_CYCLES    = 10;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 60;

  logic                 clk;
  logic                 rst_n             = 1'b0;
  logic                 cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [CFG_W-1:0]     cfg_wdata         = '0;
  logic                 in_valid          = 1'b0;
  logic                 in_stall;
  logic                 in_sensor_fault   = 1'b0;
  logic                 in_anomaly_active = 1'b0;
  logic [KIND_W-1:0]    in_anomaly_kind   = '0;
  logic [TIME_W-1:0]    in_now_ms         = '0;
  logic                 out_valid;
  logic                 out_stall         = 1'b0;
  logic [STATE_W-1:0]   out_alarm_state;
  logic [KIND_W-1:0]    out_alarm_kind;
  logic                 out_state_changed;

  // control flags from the stimulus to the receiver, set with NBAs only
  logic squeeze_req = 1'b0;
  logic calm        = 1'b0;   // no idling on either side once set

  alarm_scoreboard sb = new();

  int             updates_sent = 0;
  int             settings_run = 1;   // reset values count as the first setting
  int             idle_cycles  = 0;
  logic           anomaly_on   = 1'b0;
  logic [TIME_W-1:0] clock_ms  = '0;

  alarm_confirm_hold_fsm dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sensor_fault   (in_sensor_fault),
    .in_anomaly_active (in_anomaly_active),
    .in_anomaly_kind   (in_anomaly_kind),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_alarm_state   (out_alarm_state),
    .out_alarm_kind    (out_alarm_kind),
    .out_state_changed (out_state_changed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: check each completed transaction, then decide next cycle's
  // stall. Values read right after the edge are the ones the DUT sampled.
  // --------------------------------------------------------------------------
  int   stall_left   = 0;
  int   squeeze_left = 0;
  logic squeeze_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_alarm_state, out_alarm_kind, out_state_changed);

    if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      squeeze_left = SQUEEZE_CYCLES;
    end
    if (squeeze_left > 0) begin
      // long hold-off: the sender keeps offering, so the block backs up
      squeeze_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offers one update, optionally after a short idle burst, and holds
  // it until the DUT takes it. Called and returning at a rising edge.
  // --------------------------------------------------------------------------
  task automatic push_update(logic fault, logic anomaly, logic [KIND_W-1:0] code,
                             logic [TIME_W-1:0] now);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_sensor_fault   <= fault;
    in_anomaly_active <= anomaly;
    in_anomaly_kind   <= code;
    in_now_ms         <= now;
    do @(posedge clk); while (in_stall);
    sb.note_update(fault, anomaly, code, now);
    updates_sent++;
  endtask

  // Wait for the block to go idle, then load both timing registers.
  task automatic settle_and_program(logic [CFG_W-1:0] confirm, logic [CFG_W-1:0] hold);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CONFIRM;
    cfg_wdata <= confirm;
    @(posedge clk);
    cfg_index <= REG_HOLD;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_times(confirm, hold);
    settings_run++;
  endtask

  // Random updates: anomaly comes in runs, timestamps in 40% of updates land on or
  // right next to the confirm/hold boundary measured from the state entry time.
  task automatic random_phase(int count);
    logic              fault;
    logic [KIND_W-1:0] code;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] now;
    int                r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) anomaly_on = !anomaly_on;
      fault = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 6) == 0)
        code = KIND_W'($urandom_range(0, 1));   // low codes go through unchecked
      else
        code = KIND_W'($urandom_range(2, 15));
      if (sb.cur_state == ST_HOLD)
        span = TIME_W'(sb.hold_ms);
      else if (sb.cur_state == ST_PRE)
        span = TIME_W'(sb.confirm_ms);
      else
        span = $urandom_range(0, 1) ? TIME_W'(sb.confirm_ms) : TIME_W'(sb.hold_ms);
      r = $urandom_range(0, 99);
      if (r < 40)
        now = sb.entered_ms + span + $urandom_range(0, 2) - 1;   // boundary -1/0/+1
      else if (r < 70)
        now = clock_ms + $urandom_range(0, 3 + span / 4);
      else if (r < 90)
        now = clock_ms + $urandom_range(0, 70000);
      else
        now = $urandom();                                        // any 32-bit time
      clock_ms = now;
      push_update(fault, anomaly_on, code, now);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] confirm;
    logic [CFG_W-1:0] hold;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk with the reset timings (confirm 500, hold 2000).
    push_update(1'b0, 1'b0, 4'd5,  32'd100);          // stays normal
    push_update(1'b1, 1'b1, 4'd15, 32'd200);          // fault wins over anomaly
    push_update(1'b1, 1'b0, 4'd0,  32'd300);          // fault again, no restamp
    push_update(1'b0, 1'b1, 4'd9,  32'd400);          // recovery, anomaly ignored
    push_update(1'b0, 1'b1, 4'd0,  32'd500);          // pre-alert with kind 0
    push_update(1'b0, 1'b1, 4'd1,  32'd999);          // one short of confirm, kind 1
    push_update(1'b0, 1'b1, 4'd7,  32'd1000);         // exactly confirm -> alert
    push_update(1'b0, 1'b1, 4'd12, 32'd1100);         // kind frozen while active
    push_update(1'b0, 1'b0, 4'd0,  32'd1200);         // anomaly clears -> hold
    push_update(1'b0, 1'b0, 4'd0,  32'd3199);         // one short of hold
    push_update(1'b0, 1'b1, 4'd3,  32'd3300);         // anomaly back during hold
    push_update(1'b0, 1'b0, 4'd0,  32'd3400);         // hold again
    push_update(1'b0, 1'b0, 4'd0,  32'd5400);         // exactly hold -> normal
    push_update(1'b0, 1'b1, 4'd2,  32'd5500);         // pre-alert
    push_update(1'b0, 1'b0, 4'd2,  32'd5600);         // drops back before confirm
    push_update(1'b0, 1'b1, 4'd14, 32'hFFFF_FF00);    // pre-alert just before wrap
    push_update(1'b0, 1'b1, 4'd14, 32'h0000_00F4);    // confirm reached across wrap
    push_update(1'b1, 1'b1, 4'd14, 32'h0000_0100);    // fault while active
    push_update(1'b0, 1'b0, 4'd0,  32'h0000_0200);    // recovery

    // Zero times: transitions fire on the first update that checks them.
    settle_and_program('0, '0);
    push_update(1'b0, 1'b1, 4'd4,  32'hA5A5_5A5A);
    push_update(1'b0, 1'b1, 4'd5,  32'hA5A5_5A5A);
    push_update(1'b0, 1'b0, 4'd0,  32'hA5A5_5A5A);
    push_update(1'b0, 1'b0, 4'd0,  32'hA5A5_5A5A);
    clock_ms = 32'hA5A5_5A5A;

    // Random phases, each with its own timing setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          confirm = '1;
          hold    = '1;
        end
        1: begin
          confirm = '0;
          hold    = '0;
        end
        default: begin
          if ($urandom_range(0, 1)) begin
            confirm = CFG_W'($urandom_range(0, 65535));
            hold    = CFG_W'($urandom_range(0, 65535));
          end else begin
            confirm = CFG_W'($urandom_range(0, 40));
            hold    = CFG_W'($urandom_range(0, 40));
          end
        end
      endcase
      // calm goes up before the settle so the whole last phase runs gap-free
      if (p == PHASES - 1) calm <= 1'b1;
      settle_and_program(confirm, hold);
      if (p == 2) squeeze_req <= 1'b1;
      random_phase(ITEMS_PER_PHASE);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d updates under %0d timing settings, %0d results checked, %0d moves.",
             updates_sent, settings_run, sb.checked, sb.transitions);
    $display("Results by state: normal %0d, pre-alert %0d, alert %0d, hold %0d, fault %0d.",
             sb.state_hits[ST_NORMAL], sb.state_hits[ST_PRE], sb.state_hits[ST_ACTIVE],
             sb.state_hits[ST_HOLD], sb.state_hits[ST_FAULT]);
    if (sb.failures() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
